FILE: rtl/core/m44i_pkg.sv
// Shared types, widths and index tables for the 4x4 matrix inverse block.
// Used by m44i_sum, m44i_div and the top level under rtl/core; depends on nothing else.
package m44i_pkg;

  // Exact product and sum widths. A 3x3 minor fits 97 signed bits and the
  // determinant 130 signed bits.
  localparam int TERM_W = 128;
  localparam int ACC_W  = 136;
  localparam int DIV_W  = 164;

  // Column orders of the six terms of a 3x3 determinant, and their signs.
  localparam logic [1:0] PERM [6][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd2, 2'd1},
    '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0}
  };
  localparam logic [5:0] PERM_NEG = 6'b100110;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               mode;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic signed [63:0] det_value;
    logic               singular;
    logic               result_last;
  } result_t;

  // Which exact sum the sum engine forms.
  typedef struct packed {
    logic       is_det;
    logic [1:0] row;
    logic [1:0] col;
  } sum_cmd_t;

  // Address of the element at place pos of term p of the minor that drops
  // row r and column c.
  function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
                                           input logic [2:0] p, input logic [1:0] pos);
    logic [1:0] row;
    logic [1:0] sc;
    logic [1:0] col;
    row = (pos < r) ? pos : pos + 2'd1;
    sc  = PERM[p][pos];
    col = (sc < c) ? sc : sc + 2'd1;
    return {row, col};
  endfunction

endpackage

FILE: rtl/core/m44i_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module m44i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/m44i_sum.sv
// Sum engine: forms an exact signed cofactor or determinant as a sum of
// element products, one limb multiply at a time. Uses m44i_pkg.
module m44i_sum import m44i_pkg::*; #(
  parameter int EW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  sum_cmd_t                cmd,
  output logic [3:0]              raddr,
  input  logic [EW-1:0]           rdata,
  output logic                    done,
  output logic signed [ACC_W-1:0] sum
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WAIT  = 6'b000010,
    S_FIRST = 6'b000100,
    S_MUL   = 6'b001000,
    S_ADD   = 6'b010000,
    S_ACCUM = 6'b100000
  } state_t;

  state_t state;
  sum_cmd_t cmd_q;
  logic [2:0] p;
  logic [1:0] r_det, j, nl, k;
  logic signed [TERM_W-1:0] t, nt;
  logic signed [65:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic [1:0] r_eff, c_eff, pos;
  logic last_pos, neg_term, last_term;
  logic signed [EW-1:0] e_s;
  logic signed [32:0] e33, limb33;
  logic [31:0] limb;
  logic signed [TERM_W-1:0] nt_sum;
  logic signed [ACC_W-1:0] tx;

  assign r_eff    = cmd_q.is_det ? r_det : cmd_q.row;
  assign c_eff    = cmd_q.is_det ? 2'd3 : cmd_q.col;
  assign pos      = cmd_q.is_det ? j - 2'd1 : j;
  assign last_pos = cmd_q.is_det ? (j == 2'd3) : (j == 2'd2);
  assign neg_term = r_eff[0] ^ c_eff[0] ^ PERM_NEG[p];
  assign last_term = (p == 3'd5) && (!cmd_q.is_det || r_det == 2'd3);
  assign raddr    = (cmd_q.is_det && j == 2'd0) ? {r_det, 2'd3}
                                                : elem_addr(r_eff, c_eff, p, pos);

  assign e_s    = rdata;
  assign e33    = 33'(e_s);
  assign limb   = t[{k, 5'd0} +: 32];
  assign limb33 = (k == nl) ? {limb[31], limb} : {1'b0, limb};
  assign nt_sum = nt + (TERM_W'(prod) <<< {k, 5'd0});
  assign tx     = ACC_W'(t);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            p     <= 3'd0;
            r_det <= 2'd0;
            j     <= 2'd0;
            acc   <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= (j == 2'd0) ? S_FIRST : S_MUL;
        end
        S_FIRST: begin
          t     <= TERM_W'(e_s);
          nl    <= 2'd0;
          nt    <= '0;
          k     <= 2'd0;
          j     <= 2'd1;
          state <= S_WAIT;
        end
        S_MUL: begin
          prod  <= limb33 * e33;
          state <= S_ADD;
        end
        S_ADD: begin
          if (k == nl) begin
            t <= nt_sum;
            if (last_pos) begin
              state <= S_ACCUM;
            end else begin
              nl    <= nl + 2'd1;
              nt    <= '0;
              k     <= 2'd0;
              j     <= j + 2'd1;
              state <= S_WAIT;
            end
          end else begin
            nt    <= nt_sum;
            k     <= k + 2'd1;
            state <= S_MUL;
          end
        end
        S_ACCUM: begin
          acc <= neg_term ? acc - tx : acc + tx;
          j   <= 2'd0;
          if (last_term) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (p == 3'd5) begin
              p     <= 3'd0;
              r_det <= r_det + 2'd1;
            end else begin
              p <= p + 3'd1;
            end
            state <= S_WAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sum = acc;

endmodule

FILE: rtl/core/m44i_div.sv
// Restoring divider: (cofactor << 32) / determinant, truncated toward zero
// and saturated to the element range, one quotient bit a cycle. Uses m44i_pkg.
module m44i_div import m44i_pkg::*; #(
  parameter int EW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] cof,
  input  logic signed [ACC_W-1:0] det,
  output logic                    done,
  output logic signed [31:0]      quo
);

  localparam logic [33:0] MAXP = 34'((64'(1) << (EW - 1)) - 64'(1));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_ITER = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  logic [DIV_W-1:0] rem, dsh;
  logic [32:0] q;
  logic [5:0] cnt;
  logic neg, over;

  logic [ACC_W-1:0] cabs, dabs;
  logic geq;
  logic [33:0] qx, qs, qv;
  logic signed [EW-1:0] res_ew;

  assign cabs = cof[ACC_W-1] ? ACC_W'(-cof) : ACC_W'(cof);
  assign dabs = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);
  assign geq  = (rem >= dsh);
  assign qx   = over ? 34'h2_0000_0000 : {1'b0, q};
  assign qs   = neg ? ((qx > MAXP + 34'd1) ? MAXP + 34'd1 : qx)
                    : ((qx > MAXP) ? MAXP : qx);
  assign qv   = neg ? -qs : qs;
  assign res_ew = qv[EW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= cof[ACC_W-1] ^ det[ACC_W-1];
            rem   <= DIV_W'(cabs) << 32;
            dsh   <= DIV_W'(dabs) << 33;
            q     <= '0;
            over  <= 1'b0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // A quotient of 2^33 or more saturates whatever its low bits are.
          if (geq) begin
            over  <= 1'b1;
            state <= S_FIN;
          end else begin
            dsh   <= dsh >> 1;
            cnt   <= 6'd33;
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (geq) begin
            rem <= rem - dsh;
          end
          q   <= {q[31:0], geq};
          dsh <= dsh >> 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          quo   <= 32'(res_ew);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/matrix4x4_inverse_determinant.sv
// 4x4 matrix inverse and determinant, top level.
// Uses m44i_pkg, m44i_ram, m44i_sum and m44i_div.
//
// The block takes matrix elements one per cycle and writes each into a
// 16-entry element RAM at its row-major index; an element transfer that is
// not flagged last produces nothing. A transfer flagged last is stored too and
// then starts the computation, during which no element is taken. The exact
// determinant is formed by a sum engine that walks the 24 four-element terms
// of the fourth-column expansion through a single 33x33 multiplier, one limb
// product at a time, reading each element from the RAM as a term needs it.
// Determinant mode then gives one result with the determinant and the
// singular flag. Inverse mode gives sixteen results in row-major order:
// each is a cofactor of six three-element terms, formed on the same
// multiplier, then divided by the determinant in a restoring divider.
// A singular matrix skips the divisions and every element is the largest
// positive element value. Results leave through an output register, so the
// next matrix may be loaded while the final result still waits to be taken.
// Elements are kept between runs; load only entries that change. Every entry
// must have been written at least once before the first run reads it.
module matrix4x4_inverse_determinant import m44i_pkg::*; #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam logic signed [31:0] MAXP_32 = 32'((64'(1) << (ELEM_WIDTH - 1)) - 64'(1));

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DET_RUN = 6'b000010,
    S_DET_FIN = 6'b000100,
    S_COF_RUN = 6'b001000,
    S_DIV_RUN = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state;
  logic mode_q, sing;
  logic [3:0] k;
  logic signed [ACC_W-1:0] det_q;
  logic signed [63:0] dv;
  logic signed [31:0] val;

  logic accept, load, is_last;
  logic [3:0] kn;
  logic [3:0] raddr;
  logic [ELEM_WIDTH-1:0] rdata;
  logic sum_start, sum_done;
  sum_cmd_t sum_cmd;
  logic signed [ACC_W-1:0] sum;
  logic div_done;
  logic signed [31:0] quo;

  logic [ACC_W-1:0] dabs;
  logic dhigh, sing_now;
  logic [63:0] detq;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign load       = (state == S_EMIT) && (!result_valid || result_ready);
  assign is_last    = mode_q || (k == 4'd15);
  assign kn         = k + 4'd1;

  // Determinant as Q32.32: the exact value truncated toward zero, saturated.
  assign sing_now = (det_q == '0);
  assign dabs     = det_q[ACC_W-1] ? ACC_W'(-det_q) : ACC_W'(det_q);
  assign dhigh    = |dabs[ACC_W-1:96];
  assign detq     = dabs[95:32];

  m44i_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(16)) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (item.element_index),
    .wdata (item.element_value[ELEM_WIDTH-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  m44i_sum #(.EW(ELEM_WIDTH)) u_sum (
    .clk   (clk),
    .rst   (rst),
    .start (sum_start),
    .cmd   (sum_cmd),
    .raddr (raddr),
    .rdata (rdata),
    .done  (sum_done),
    .sum   (sum)
  );

  m44i_div #(.EW(ELEM_WIDTH)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_COF_RUN) && sum_done),
    .cof   (sum),
    .det   (det_q),
    .done  (div_done),
    .quo   (quo)
  );

  // Work for the sum engine: the determinant after the last element, the
  // first inverse-mode cofactor once the determinant is known nonzero, then the
  // cofactor for each following result as the previous one leaves. The inverse at
  // row i, column j takes cofactor (j, i).
  always_comb begin
    sum_start = 1'b0;
    sum_cmd   = '{is_det: 1'b1, row: 2'd0, col: 2'd0};
    unique case (state)
      S_IDLE: begin
        sum_start = accept && item.last;
      end
      S_DET_FIN: begin
        sum_start = !mode_q && !sing_now;
        sum_cmd   = '{is_det: 1'b0, row: 2'd0, col: 2'd0};
      end
      S_EMIT: begin
        sum_start = load && !is_last && !sing;
        sum_cmd   = '{is_det: 1'b0, row: kn[1:0], col: kn[3:2]};
      end
      default: begin
        sum_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && item.last) begin
            mode_q <= item.mode;
            state  <= S_DET_RUN;
          end
        end
        S_DET_RUN: begin
          if (sum_done) begin
            det_q <= sum;
            state <= S_DET_FIN;
          end
        end
        S_DET_FIN: begin
          sing <= sing_now;
          k    <= 4'd0;
          if (det_q[ACC_W-1]) begin
            dv <= (dhigh || detq > 64'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
                                                            : -$signed(detq);
          end else begin
            dv <= (dhigh || detq[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(detq);
          end
          if (mode_q) begin
            val   <= '0;
            state <= S_EMIT;
          end else if (sing_now) begin
            val   <= MAXP_32;
            state <= S_EMIT;
          end else begin
            state <= S_COF_RUN;
          end
        end
        S_COF_RUN: begin
          if (sum_done) begin
            state <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          if (div_done) begin
            val   <= quo;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              k <= kn;
              if (!sing) begin
                state <= S_COF_RUN;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= '{out_index: k, out_value: val, det_value: dv,
                  singular: sing, result_last: is_last};
    end
  end

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_RUN)
    else $error("divider finished outside its state");

  a_sum_in_run_state: assert property (@(posedge clk) disable iff (rst)
    sum_done |-> (state == S_DET_RUN || state == S_COF_RUN))
    else $error("sum engine finished outside a run state");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_last |-> (result.out_index == 4'd15 ||
                                            result.out_index == 4'd0))
    else $error("final result at an unexpected index");

  a_singular_full_scale: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.singular && result.out_index != 4'd0 |->
      result.out_value == MAXP_32)
    else $error("singular inverse element is not full scale");

endmodule

FILE: bench/tb_matrix4x4_inverse_determinant.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 4x4 matrix inverse and determinant block.
// Depends on m44i_pkg and the RTL under rtl/core; needs no files or arguments.
module tb_matrix4x4_inverse_determinant;
  import m44i_pkg::*;

  localparam int GAP_MAX   = 16;
  localparam int IDLE_LIMIT = 30000;
  localparam int DRAIN_WAIT = 600;

  typedef logic signed [191:0] wide_t;

  // One pending element transfer. When hold is set, the driver waits until
  // every expected result has come back before it offers this element.
  typedef struct {
    item_t it;
    bit    hold;
  } load_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  load_t   load_q[$];
  result_t expected_q[$];
  logic signed [31:0] elem_mirror[16];

  int errors;
  int sent_items;
  int got_results;
  int inv_runs;
  int det_runs;
  int singular_runs;
  int gap_left;
  int stall_left;
  int idle_cycles;
  bit calm;

  matrix4x4_inverse_determinant dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Signed cofactor (r,c) of the mirrored matrix: the 3x3 minor that drops
  // row r and column c, negated when r+c is odd. Products are exact.
  function automatic wide_t cofactor_of(input int r, input int c);
    wide_t s[3][3];
    wide_t m;
    int si;
    int sj;
    si = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin
        sj = 0;
        for (int j = 0; j < 4; j++) begin
          if (j != c) begin
            s[si][sj] = elem_mirror[i * 4 + j];
            sj++;
          end
        end
        si++;
      end
    end
    m = s[0][0] * (s[1][1] * s[2][2] - s[1][2] * s[2][1])
      - s[0][1] * (s[1][0] * s[2][2] - s[1][2] * s[2][0])
      + s[0][2] * (s[1][0] * s[2][1] - s[1][1] * s[2][0]);
    return ((r + c) % 2 == 1) ? -m : m;
  endfunction

  // Q48.48 cofactor over Q64.64 determinant gives Q16.16, truncated toward
  // zero and saturated to the signed 32-bit range.
  function automatic logic [31:0] inverse_elem(input wide_t cof, input wide_t det);
    logic [191:0] num;
    logic [191:0] den;
    logic [191:0] q;
    bit neg;
    neg = (cof < 0) != (det < 0);
    num = (cof < 0) ? -cof : cof;
    num = num << 32;
    den = (det < 0) ? -det : det;
    q = num / den;
    if (!neg) return (q > 192'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 192'h8000_0000) q = 192'h8000_0000;
    return -q[31:0];
  endfunction

  // Updates the mirrored matrix and, on a last element, queues the results.
  task automatic predict_results(input item_t it);
    wide_t det;
    wide_t mag;
    logic [191:0] whole;
    logic [63:0] det_q;
    result_t r;
    elem_mirror[it.element_index] = it.element_value;
    if (it.last) begin
      det = 0;
      for (int row = 0; row < 4; row++)
        det = det + wide_t'(elem_mirror[row * 4 + 3]) * cofactor_of(row, 3);
      mag = (det < 0) ? -det : det;
      whole = mag >> 32;
      if (det < 0) begin
        if (whole > {128'd0, 64'h8000_0000_0000_0000}) whole = {128'd0, 64'h8000_0000_0000_0000};
        det_q = -whole[63:0];
      end else begin
        if (whole > {128'd0, 64'h7FFF_FFFF_FFFF_FFFF}) whole = {128'd0, 64'h7FFF_FFFF_FFFF_FFFF};
        det_q = whole[63:0];
      end
      r.det_value = det_q;
      r.singular  = (det == 0);
      if (r.singular) singular_runs++;
      if (it.mode) begin
        det_runs++;
        r.out_index   = 4'd0;
        r.out_value   = 32'sd0;
        r.result_last = 1'b1;
        expected_q.push_back(r);
      end else begin
        inv_runs++;
        for (int k = 0; k < 16; k++) begin
          r.out_index   = k[3:0];
          r.out_value   = r.singular ? 32'h7FFF_FFFF : inverse_elem(cofactor_of(k % 4, k / 4), det);
          r.result_last = (k == 15);
          expected_q.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, got_results);
  endtask

  task automatic queue_elem(input int idx, input logic [31:0] val, input bit mode,
                            input bit last, input bit hold);
    load_t l;
    l.it.element_index = idx[3:0];
    l.it.element_value = val;
    l.it.mode          = mode;
    l.it.last          = last;
    l.hold             = hold;
    load_q.push_back(l);
  endtask

  // Element values lean toward small integers so that many inverses land in
  // range, with full-range words and the extremes mixed in.
  function automatic logic [31:0] random_elem();
    case ($urandom_range(0, 6))
      0, 1:    return ($signed($urandom_range(0, 8)) - 4) <<< 16;
      2:       return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      3:       return $urandom;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h8000_0000;
      default: return 32'h0;
    endcase
  endfunction

  // Driver: offers one element at a time; the valid is only ever changed when
  // the current transfer has completed or nothing is on offer.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
      gap_left   <= 0;
    end else begin
      if (item_valid && item_ready) begin
        predict_results(item);
        sent_items++;
      end
      if (!item_valid || item_ready) begin
        if (gap_left > 0 || load_q.size() == 0 ||
            (load_q[0].hold && expected_q.size() != 0)) begin
          item_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          item       <= load_q[0].it;
          item_valid <= 1'b1;
          void'(load_q.pop_front());
          if ($urandom_range(0, 15) == 0) calm = !calm;
          gap_left <= calm ? 0 : $urandom_range(0, GAP_MAX);
        end
      end
    end
  end

  // Monitor: compares each result transfer field by field with the oldest
  // expectation and throttles result_ready with random stalls.
  always @(posedge clk) begin
    result_t want;
    int st;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready) begin
        got_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result.out_value, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (result.out_index !== want.out_index)
            report_mismatch("out_index", result.out_index, want.out_index);
          if (result.out_value !== want.out_value)
            report_mismatch("out_value", result.out_value, want.out_value);
          if (result.det_value !== want.det_value)
            report_mismatch("det_value", result.det_value, want.det_value);
          if (result.singular !== want.singular)
            report_mismatch("singular", result.singular, want.singular);
          if (result.result_last !== want.result_last)
            report_mismatch("result_last", result.result_last, want.result_last);
        end
        st = calm ? 0 : $urandom_range(0, GAP_MAX);
        result_ready <= (st == 0);
        stall_left   <= (st > 0) ? st - 1 : 0;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: the longest stretch without any transfer is the determinant
  // followed by the first quotient of an inverse, so the limit is set well
  // above that.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int order[$];
    int pick;
    int n;
    int tmp;
    bit mode;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    errors = 0;
    sent_items = 0;
    got_results = 0;
    inv_runs = 0;
    det_runs = 0;
    singular_runs = 0;
    idle_cycles = 0;
    calm = 1'b0;

    // Directed: an identity matrix loaded whole and inverted.
    for (int k = 0; k < 16; k++)
      queue_elem(k, (k % 5 == 0) ? 32'h0001_0000 : 32'h0, 1'b0, k == 15, 1'b0);
    // A zeroed diagonal entry makes the matrix singular; determinant only.
    queue_elem(0, 32'h0, 1'b1, 1'b1, 1'b0);
    // The same singular matrix in inverse mode gives full scale everywhere.
    queue_elem(10, 32'h0001_0000, 1'b0, 1'b1, 1'b1);
    // Extreme diagonal values push the quotients and determinant to saturate.
    queue_elem(0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    queue_elem(5, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    queue_elem(10, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
    queue_elem(15, 32'h0000_0001, 1'b0, 1'b1, 1'b0);
    queue_elem(15, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    queue_elem(3, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);

    // Random: mostly whole or partial loads closed by a last element, with
    // stray elements in between that produce nothing.
    n = load_q.size();
    while (load_q.size() - n < 135) begin
      mode = $urandom_range(0, 1);
      pick = $urandom_range(0, 9);
      order.delete();
      if (pick < 4) begin
        for (int k = 0; k < 16; k++) order.push_back(k);
        for (int k = 15; k > 0; k--) begin
          tmp = $urandom_range(0, k);
          {order[k], order[tmp]} = {order[tmp], order[k]};
        end
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 4)) order.push_back($urandom_range(0, 15));
      end else begin
        queue_elem($urandom_range(0, 15), random_elem(), $urandom_range(0, 1), 1'b0, 1'b0);
      end
      foreach (order[k])
        queue_elem(order[k], random_elem(), mode, k == order.size() - 1,
                   k == 0 && $urandom_range(0, 19) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (load_q.size() == 0 && !item_valid);
    wait (expected_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d element transfers: %0d inverse and %0d determinant runs, %0d singular.",
             sent_items, inv_runs, det_runs, singular_runs);
    $display("Checked %0d result transfers with %0d mismatches.", got_results, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
